[hw/rtl/bba_pkg.sv]
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
    } t_in_item;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] first_block;
    } t_out_item;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             data;
    } t_wr_req;

endpackage

[hw/rtl/bba_bitmap.sv]
module bba_bitmap (
    input  logic                      i_clk,
    input  bba_pkg::t_wr_req          i_wr,
    input  logic [bba_pkg::IDX_W-1:0] i_rd_addr,
    output logic                      o_rd_bit
);

    logic r_mem [bba_pkg::MAX_BLOCKS];
    logic r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_bit <= r_mem[i_rd_addr];
    end

    assign o_rd_bit = r_rd_bit;

endmodule

[hw/rtl/bitmap_block_allocator_unit.sv]
// Block allocator over a used/free bitmap with a next-fit search cursor. Each
// input transfer carries one operation: allocate (scan from the cursor for a
// run of free blocks, never across the wrap to block 0), free (clear a run,
// lowering the cursor if the run starts below it) or clear all; each gives
// exactly one result transfer. The bitmap sits in a one-bit-wide RAM with one
// write and one registered read port: an allocate scans one block bit per
// cycle and then marks the run, a free clears its run, and clear all sweeps
// the whole RAM. After reset the same sweep runs once with o_in_stall high.
// The block works on one item at a time and stalls input until the item's
// result has been loaded into the output register; a waiting result does not
// block acceptance of the next item.
// The block count register may be written only while the block is idle.
module bitmap_block_allocator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  bba_pkg::t_in_item         i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output bba_pkg::t_out_item        o_out_data,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int IW = bba_pkg::IDX_W;
    localparam int CW = bba_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    t_state             r_state,     n_state;
    logic [CW-1:0]      r_cfg,       n_cfg;
    logic [IW-1:0]      r_cursor,    n_cursor;
    logic [CW-1:0]      r_item_cnt,  n_item_cnt;
    logic [IW-1:0]      r_start,     n_start;
    logic [IW-1:0]      r_pos,       n_pos;
    logic               r_issue,     n_issue;
    logic               r_chk_valid, n_chk_valid;
    logic [IW-1:0]      r_chk_pos,   n_chk_pos;
    logic               r_chk_last,  n_chk_last;
    logic [CW-1:0]      r_run,       n_run;
    logic [CW-1:0]      r_ptr,       n_ptr;
    logic [CW-1:0]      r_lim,       n_lim;
    logic               r_wr_bit,    n_wr_bit;
    logic               r_reply,     n_reply;
    logic               r_res_ok,    n_res_ok;
    logic [IW-1:0]      r_res_first, n_res_first;
    logic               r_out_valid, n_out_valid;
    bba_pkg::t_out_item r_out_data,  n_out_data;

    logic               w_rd_bit;
    bba_pkg::t_wr_req   w_wr;
    logic [CW-1:0]      w_live_n;
    logic               w_accept;
    logic [IW-1:0]      w_scan_start;
    logic [CW-1:0]      w_pos_inc;
    logic [IW-1:0]      w_next_pos;
    logic [CW-1:0]      w_run_prev;
    logic [CW-1:0]      w_run_new;
    logic [CW-1:0]      w_chk_inc;
    logic [CW-1:0]      w_run_lo;
    logic [CW:0]        w_free_sum;
    logic [CW-1:0]      w_free_lim;

    bba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_pos),
        .o_rd_bit  (w_rd_bit)
    );

    // Live block count: zero reads as one, anything above the RAM depth saturates.
    always_comb begin
        if (r_cfg == '0) begin
            w_live_n = CW'(1);
        end else if (r_cfg > CW'(bba_pkg::MAX_BLOCKS)) begin
            w_live_n = CW'(bba_pkg::MAX_BLOCKS);
        end else begin
            w_live_n = r_cfg;
        end
    end

    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_scan_start = ({1'b0, r_cursor} < w_live_n) ? r_cursor : '0;

    // Read-side address walk: wrap at the live count, stop on return to the start.
    assign w_pos_inc  = {1'b0, r_pos} + CW'(1);
    assign w_next_pos = (w_pos_inc == w_live_n) ? '0 : w_pos_inc[IW-1:0];

    // Check side: the run count restarts at block 0 so runs never span the wrap.
    assign w_run_prev = (r_chk_pos == '0) ? '0 : r_run;
    assign w_run_new  = w_rd_bit ? '0 : (w_run_prev + CW'(1));
    assign w_chk_inc  = {1'b0, r_chk_pos} + CW'(1);
    assign w_run_lo   = w_chk_inc - r_item_cnt;

    // Free bound: stop at the end of the run or the live count, whichever is first.
    assign w_free_sum = {2'b00, i_in_data.start_block} + {1'b0, i_in_data.block_count};
    assign w_free_lim = (w_free_sum < {1'b0, w_live_n}) ? w_free_sum[CW-1:0] : w_live_n;

    // One write per cycle for marking, freeing and sweeping alike.
    always_comb begin
        w_wr.en   = (r_state == ST_WRITE) && (r_ptr < r_lim);
        w_wr.addr = r_ptr[IW-1:0];
        w_wr.data = r_wr_bit;
    end

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_cursor    = r_cursor;
        n_item_cnt  = r_item_cnt;
        n_start     = r_start;
        n_pos       = r_pos;
        n_issue     = r_issue;
        n_chk_valid = r_chk_valid;
        n_chk_pos   = r_chk_pos;
        n_chk_last  = r_chk_last;
        n_run       = r_run;
        n_ptr       = r_ptr;
        n_lim       = r_lim;
        n_wr_bit    = r_wr_bit;
        n_reply     = r_reply;
        n_res_ok    = r_res_ok;
        n_res_first = r_res_first;
        n_out_data  = r_out_data;
        // drop the result once the far side takes it
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            n_cfg = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_ok    = 1'b0;
                    n_res_first = '0;
                    n_ptr       = '0;
                    n_reply     = 1'b1;
                    n_state     = ST_RESULT;
                    case (i_in_data.kind)
                        bba_pkg::KIND_ALLOC: begin
                            if ((i_in_data.block_count != '0) &&
                                (i_in_data.block_count <= w_live_n)) begin
                                n_item_cnt  = i_in_data.block_count;
                                n_start     = w_scan_start;
                                n_pos       = w_scan_start;
                                n_issue     = 1'b1;
                                n_chk_valid = 1'b0;
                                n_chk_last  = 1'b0;
                                n_run       = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        bba_pkg::KIND_FREE: begin
                            if (i_in_data.start_block < r_cursor) begin
                                n_cursor = i_in_data.start_block;
                            end
                            n_ptr    = {1'b0, i_in_data.start_block};
                            n_lim    = w_free_lim;
                            n_wr_bit = 1'b0;
                            n_res_ok = 1'b1;
                            n_state  = ST_WRITE;
                        end
                        bba_pkg::KIND_CLEAR: begin
                            n_cursor = '0;
                            n_lim    = CW'(bba_pkg::MAX_BLOCKS);
                            n_wr_bit = 1'b0;
                            n_res_ok = 1'b1;
                            n_state  = ST_WRITE;
                        end
                        default: begin
                            // unused kind: no bitmap change, failing result
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue: the read of r_pos lands in the RAM output register this edge
                n_chk_valid = r_issue;
                n_chk_pos   = r_pos;
                n_chk_last  = (w_next_pos == r_start);
                if (r_issue) begin
                    n_pos   = w_next_pos;
                    n_issue = (w_next_pos != r_start);
                end
                // check: test the registered bit from the last issued read
                if (r_chk_valid) begin
                    n_run = w_run_new;
                    if (w_run_new == r_item_cnt) begin
                        n_issue     = 1'b0;
                        n_chk_valid = 1'b0;
                        n_ptr       = w_run_lo;
                        n_lim       = w_chk_inc;
                        n_wr_bit    = 1'b1;
                        n_cursor    = (w_chk_inc == w_live_n) ? '0 : w_chk_inc[IW-1:0];
                        n_res_ok    = 1'b1;
                        n_res_first = w_run_lo[IW-1:0];
                        n_state     = ST_WRITE;
                    end else if (r_chk_last) begin
                        n_issue     = 1'b0;
                        n_chk_valid = 1'b0;
                        n_state     = ST_RESULT;
                    end
                end
            end

            ST_WRITE: begin
                if (r_ptr < r_lim) begin
                    n_ptr = r_ptr + CW'(1);
                end else begin
                    n_state = r_reply ? ST_RESULT : ST_IDLE;
                end
            end

            ST_RESULT: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_data.ok          = r_res_ok;
                    n_out_data.first_block = r_res_first;
                    n_state                = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // start with a full clearing sweep of the bitmap
            r_state     <= ST_WRITE;
            r_cfg       <= CW'(bba_pkg::MAX_BLOCKS);
            r_cursor    <= '0;
            r_item_cnt  <= '0;
            r_start     <= '0;
            r_pos       <= '0;
            r_issue     <= 1'b0;
            r_chk_valid <= 1'b0;
            r_chk_pos   <= '0;
            r_chk_last  <= 1'b0;
            r_run       <= '0;
            r_ptr       <= '0;
            r_lim       <= CW'(bba_pkg::MAX_BLOCKS);
            r_wr_bit    <= 1'b0;
            r_reply     <= 1'b0;
            r_res_ok    <= 1'b0;
            r_res_first <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_cursor    <= n_cursor;
            r_item_cnt  <= n_item_cnt;
            r_start     <= n_start;
            r_pos       <= n_pos;
            r_issue     <= n_issue;
            r_chk_valid <= n_chk_valid;
            r_chk_pos   <= n_chk_pos;
            r_chk_last  <= n_chk_last;
            r_run       <= n_run;
            r_ptr       <= n_ptr;
            r_lim       <= n_lim;
            r_wr_bit    <= n_wr_bit;
            r_reply     <= n_reply;
            r_res_ok    <= n_res_ok;
            r_res_first <= n_res_first;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
